@@ rtl/core/ptpu_pkg.sv @@
// Package: shared types, constants and CORDIC helpers for the polar target update.
`timescale 1ns / 1ps
package ptpu_pkg;

    localparam int XY_W = 28;          // CORDIC x/y width, 1/256 range units
    localparam int Z_W  = 32;          // CORDIC angle width, 2^-22 degree
    localparam int TABLE_LEN = 24;
    localparam logic [14:0] FULL_TURN   = 15'd23040;
    localparam logic [14:0] QUARTER     = 15'd5760;
    localparam logic [14:0] HALF_TURN   = 15'd11520;
    localparam logic [14:0] THREE_QTR   = 15'd17280;
    localparam logic [29:0] K_Q30       = 30'd652032874;
    localparam logic [31:0] RECIP_125   = 32'd2199023256;  // ceil(2^38 / 125)

    // Configuration register indexes
    localparam logic [1:0] CFG_INTERVAL_MS   = 2'd0;
    localparam logic [1:0] CFG_DETECT_RADIUS = 2'd1;

    typedef logic signed [XY_W-1:0] t_xy;
    typedef logic signed [Z_W-1:0]  t_ang;

    typedef struct packed {
        t_xy  x;
        t_ang z;
    } t_rot_init;

    // atan(2^-i) in 2^-22 degree
    function automatic t_ang atan_val(input int idx);
        t_ang v;
        case (idx)
            0:  v = 32'sd188743680;
            1:  v = 32'sd111421900;
            2:  v = 32'sd58872272;
            3:  v = 32'sd29884485;
            4:  v = 32'sd15000234;
            5:  v = 32'sd7507429;
            6:  v = 32'sd3754631;
            7:  v = 32'sd1877430;
            8:  v = 32'sd938729;
            9:  v = 32'sd469366;
            10: v = 32'sd234683;
            11: v = 32'sd117342;
            12: v = 32'sd58671;
            13: v = 32'sd29335;
            14: v = 32'sd14668;
            15: v = 32'sd7334;
            16: v = 32'sd3667;
            17: v = 32'sd1833;
            18: v = 32'sd917;
            19: v = 32'sd458;
            20: v = 32'sd229;
            21: v = 32'sd115;
            22: v = 32'sd57;
            23: v = 32'sd29;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Wrap a 15 bit angle into 0..23039
    function automatic logic [14:0] wrap_angle(input logic [14:0] a);
        logic [14:0] r;
        r = (a >= FULL_TURN) ? a - FULL_TURN : a;
        return r;
    endfunction

    // Fold rotation start into +-90 degrees: negate x for the back half-plane
    function automatic t_rot_init rot_fold(input logic [24:0] mag, input logic [14:0] a);
        t_rot_init   r;
        logic [15:0] d;
        if (a > QUARTER && a <= THREE_QTR) begin
            r.x = -t_xy'({3'b000, mag});
            d   = {1'b0, a} - {1'b0, HALF_TURN};
        end else if (a > THREE_QTR) begin
            r.x = t_xy'({3'b000, mag});
            d   = {1'b0, a} - {1'b0, FULL_TURN};
        end else begin
            r.x = t_xy'({3'b000, mag});
            d   = {1'b0, a};
        end
        r.z = {d, 16'h0000};
        return r;
    endfunction

endpackage

@@ rtl/core/ptpu_cordic_cell.sv @@
// One registered CORDIC micro-rotation cell, rotation or vectoring mode.
`timescale 1ns / 1ps
module ptpu_cordic_cell #(
    parameter int STAGE  = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic           i_clk,
    input  ptpu_pkg::t_xy  i_x,
    input  ptpu_pkg::t_xy  i_y,
    input  ptpu_pkg::t_ang i_z,
    output ptpu_pkg::t_xy  o_x,
    output ptpu_pkg::t_xy  o_y,
    output ptpu_pkg::t_ang o_z
);
    import ptpu_pkg::*;

    localparam t_ang ATAN = atan_val(STAGE);

    t_xy  r_x, r_y, n_x, n_y;
    t_ang r_z, n_z;
    t_xy  xs, ys;
    logic dir;

    // Direction: drive z to zero (rotate) or y to zero (vector)
    always_comb begin
        xs  = i_x >>> STAGE;
        ys  = i_y >>> STAGE;
        dir = VECTOR ? i_y[XY_W-1] : ~i_z[Z_W-1];
        if (dir) begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

@@ rtl/core/polar_target_position_update.sv @@
// Top level: pipelined polar dead-reckoning update of one radar target.
`timescale 1ns / 1ps
// Usage:
//   Command channel: drive the four target fields with start high; the
//   transaction is taken at any edge where start is high and busy is low.
//   busy never rises, so a new target may be issued every cycle.
//   Result: o_valid strobes for one cycle with new range, bearing and the
//   out_of_range flag once the command has passed the whole pipeline.
//   Throughput is one target per cycle; the pipeline holds the two rows of
//   CORDIC cells (rotation of position and displacement side by side, then
//   vectoring) plus the scaling multipliers.
//   Results leave in command order; the receiver cannot stall them and must
//   take each one in its strobe cycle.
//   Configuration: a write transaction on i_cfg_valid/o_cfg_ready with an
//   index and data; ready is always high. Write only while no target is in
//   flight. Index 0 is interval_ms, index 1 detect_radius, others ignored.
//   Reset (synchronous, active low) clears the pipeline valids and loads
//   interval_ms = 100 and detect_radius = 16000.
module polar_target_position_update #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_start_range,
    input  logic [14:0] i_start_bearing,
    input  logic [11:0] i_target_speed,
    input  logic [14:0] i_heading,
    output logic        o_valid,
    output logic [15:0] o_new_range,
    output logic [14:0] o_new_bearing,
    output logic        o_out_of_range,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import ptpu_pkg::*;

    localparam int NS  = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int LAT = 2 * NS + 8;

    // Configuration registers
    logic [13:0] r_interval_ms;
    logic [15:0] r_detect_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval_ms   <= 14'd100;
            r_detect_radius <= 16'd16000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_INTERVAL_MS:   r_interval_ms   <= i_cfg_data[13:0];
                CFG_DETECT_RADIUS: r_detect_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // Valid shift line
    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[LAT-2:0], start && !busy};
    end

    // Stage 1: wrap angles, speed * interval
    logic [15:0] r_s1_range;
    logic [14:0] r_s1_bear, r_s1_head;
    logic [25:0] r_s1_p;
    always_ff @(posedge i_clk) begin
        r_s1_range <= i_start_range;
        r_s1_bear  <= wrap_angle(i_start_bearing);
        r_s1_head  <= wrap_angle(i_heading);
        r_s1_p     <= i_target_speed * r_interval_ms;
    end

    // Stage 2: reciprocal multiply for /1000, gain scale of the position
    logic [30:0] s2_q;
    logic [62:0] r_s2_qm;
    logic [53:0] r_s2_rprod;
    logic [14:0] r_s2_bear, r_s2_head;
    assign s2_q = {r_s1_p, 5'b00000} + 31'd62;
    always_ff @(posedge i_clk) begin
        r_s2_qm    <= s2_q * RECIP_125;
        r_s2_rprod <= {r_s1_range, 8'h00} * K_Q30;
        r_s2_bear  <= r_s1_bear;
        r_s2_head  <= r_s1_head;
    end

    // Stage 3: displacement and scaled position magnitude
    logic [53:0] s3_rsum;
    logic [24:0] r_s3_move;
    logic [23:0] r_s3_pmag;
    logic [14:0] r_s3_bear, r_s3_head;
    assign s3_rsum = r_s2_rprod + 54'(1 << 29);
    always_ff @(posedge i_clk) begin
        r_s3_move <= r_s2_qm[62:38];
        r_s3_pmag <= s3_rsum[53:30];
        r_s3_bear <= r_s2_bear;
        r_s3_head <= r_s2_head;
    end

    // Stage 4: gain scale of the displacement
    logic [54:0] r_s4_dprod;
    logic [23:0] r_s4_pmag;
    logic [14:0] r_s4_bear, r_s4_head;
    always_ff @(posedge i_clk) begin
        r_s4_dprod <= r_s3_move * K_Q30;
        r_s4_pmag  <= r_s3_pmag;
        r_s4_bear  <= r_s3_bear;
        r_s4_head  <= r_s3_head;
    end

    // Stage 5: quadrant fold of both vectors
    logic [54:0] s5_dsum;
    t_rot_init   s5_p, s5_d;
    t_xy         r_s5_px, r_s5_dx;
    t_ang        r_s5_pz, r_s5_dz;
    assign s5_dsum = r_s4_dprod + 55'(1 << 29);
    assign s5_p    = rot_fold({1'b0, r_s4_pmag}, r_s4_bear);
    assign s5_d    = rot_fold(s5_dsum[54:30], r_s4_head);
    always_ff @(posedge i_clk) begin
        r_s5_px <= s5_p.x;
        r_s5_pz <= s5_p.z;
        r_s5_dx <= s5_d.x;
        r_s5_dz <= s5_d.z;
    end

    // Rotation row: position and displacement cells side by side
    t_xy  px [NS+1];
    t_xy  py [NS+1];
    t_ang pz [NS+1];
    t_xy  dx [NS+1];
    t_xy  dy [NS+1];
    t_ang dz [NS+1];
    assign px[0] = r_s5_px;
    assign py[0] = '0;
    assign pz[0] = r_s5_pz;
    assign dx[0] = r_s5_dx;
    assign dy[0] = '0;
    assign dz[0] = r_s5_dz;

    for (genvar g = 0; g < NS; g++) begin : g_rot
        ptpu_cordic_cell #(.STAGE(g), .VECTOR(1'b0)) u_pos (
            .i_clk(i_clk), .i_x(px[g]), .i_y(py[g]), .i_z(pz[g]),
            .o_x(px[g+1]), .o_y(py[g+1]), .o_z(pz[g+1])
        );
        ptpu_cordic_cell #(.STAGE(g), .VECTOR(1'b0)) u_dsp (
            .i_clk(i_clk), .i_x(dx[g]), .i_y(dy[g]), .i_z(dz[g]),
            .o_x(dx[g+1]), .o_y(dy[g+1]), .o_z(dz[g+1])
        );
    end

    // Add stage: sum, zero detect, fold into right half-plane
    t_xy  sx, sy;
    t_xy  r_ax, r_ay;
    t_ang r_az;
    logic r_azero;
    assign sx = px[NS] + dx[NS];
    assign sy = py[NS] + dy[NS];
    always_ff @(posedge i_clk) begin
        r_azero <= (sx == '0) && (sy == '0);
        if (sx[XY_W-1]) begin
            r_ax <= -sx;
            r_ay <= -sy;
            r_az <= {1'b0, HALF_TURN, 16'h0000};
        end else begin
            r_ax <= sx;
            r_ay <= sy;
            r_az <= '0;
        end
    end

    // Vectoring row
    t_xy  vx [NS+1];
    t_xy  vy [NS+1];
    t_ang vz [NS+1];
    logic [NS:0] vzero;
    assign vx[0]    = r_ax;
    assign vy[0]    = r_ay;
    assign vz[0]    = r_az;
    assign vzero[0] = r_azero;

    for (genvar g = 0; g < NS; g++) begin : g_vec
        ptpu_cordic_cell #(.STAGE(g), .VECTOR(1'b1)) u_vec (
            .i_clk(i_clk), .i_x(vx[g]), .i_y(vy[g]), .i_z(vz[g]),
            .o_x(vx[g+1]), .o_y(vy[g+1]), .o_z(vz[g+1])
        );
        logic r_zero;
        always_ff @(posedge i_clk) r_zero <= vzero[g];
        assign vzero[g+1] = r_zero;
    end

    // Gain stage on magnitude
    logic [56:0] r_gprod;
    t_ang        r_gz;
    logic        r_gzero;
    always_ff @(posedge i_clk) begin
        r_gprod <= vx[NS][26:0] * K_Q30;
        r_gz    <= vz[NS];
        r_gzero <= vzero[NS];
    end

    // Output stage: rounding, saturation, bearing wrap, radius compare
    logic [56:0] gsum;
    logic [26:0] mag;
    logic [26:0] rsum;
    logic [18:0] nr;
    t_ang        zr;
    logic signed [15:0] nb;
    logic [15:0] nbw;
    logic [15:0] n_range;
    logic [14:0] n_bear;
    logic        n_flag;
    always_comb begin
        gsum = r_gprod + 57'(1 << 29);
        mag  = gsum[56:30];
        rsum = mag + 27'd128;
        nr   = rsum[26:8];
        zr   = r_gz + 32'sd32768;
        nb   = zr[31:16];
        nbw  = nb[15] ? 16'(nb + 16'sd23040) : 16'(nb);
        if (r_gzero) begin
            n_range = '0;
            n_bear  = '0;
            n_flag  = (r_detect_radius == '0);
        end else if (nr > 19'd65535) begin
            n_range = 16'hFFFF;
            n_bear  = nbw[14:0];
            n_flag  = 1'b1;
        end else begin
            n_range = nr[15:0];
            n_bear  = nbw[14:0];
            n_flag  = (nr[15:0] >= r_detect_radius);
        end
    end

    always_ff @(posedge i_clk) begin
        o_new_range    <= n_range;
        o_new_bearing  <= n_bear;
        o_out_of_range <= n_flag;
    end

    assign o_valid = r_vld[LAT-1];

    // Checks
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_valid) else $error("result missing");
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_new_range >= r_detect_radius) |-> o_out_of_range)
        else $error("flag not set");
    a_bear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_new_bearing < FULL_TURN) else $error("bearing not wrapped");
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_of_range |-> o_new_range != 16'hFFFF)
        else $error("saturation without flag");

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the polar target position update: random and directed targets, scoreboard check.
`timescale 1ns / 1ps
module tb_top;
    import ptpu_pkg::*;

    localparam int STAGES = 16;
    localparam int LATENCY = 2 * STAGES + 8;
    // Indexes the block ignores
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    typedef struct {
        logic [15:0] rng;
        logic [14:0] brg;
        logic        lost;
    } t_track_fix;

    // Arctangent steps in 2^-22 degree
    localparam longint ATAN_STEP [24] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
        3754631, 1877430, 938729, 469366, 234683, 117342,
        58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29};

    // Expected track fixes and their check
    class track_scoreboard;
        t_track_fix fixes[$];
        int errors = 0;

        function longint scale_gain(longint m);
            return (m * 64'd652032874 + (64'd1 << 29)) >>> 30;
        endfunction

        // Polar to Cartesian by CORDIC rotation
        function void polar_to_xy(longint mag, longint a, output longint ox, output longint oy);
            longint x, y, z, xs, ys;
            x = mag;
            y = 0;
            if (a > 5760 && a <= 17280) begin
                x = -x;
                z = (a - 11520) * 65536;
            end else if (a > 17280) begin
                z = (a - 23040) * 65536;
            end else begin
                z = a * 65536;
            end
            for (int i = 0; i < STAGES; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys; y = y + xs; z -= ATAN_STEP[i];
                end else begin
                    x = x + ys; y = y - xs; z += ATAN_STEP[i];
                end
            end
            ox = x;
            oy = y;
        endfunction

        // Dead-reckoning step for one accepted target
        function void note_target(logic [15:0] rng, logic [14:0] brg, logic [11:0] spd,
                                  logic [14:0] hdg, logic [13:0] ival, logic [15:0] radius);
            longint b, h, move, px, py, dx, dy, x, y, z, xs, ys, nr, nb;
            t_track_fix f;
            b = longint'(brg) % 23040;
            h = longint'(hdg) % 23040;
            move = (longint'(spd) * longint'(ival) * 256 + 500) / 1000;
            polar_to_xy(scale_gain(longint'(rng) << 8), b, px, py);
            polar_to_xy(scale_gain(move), h, dx, dy);
            x = px + dx;
            y = py + dy;
            z = 0;
            if (x == 0 && y == 0) begin
                nr = 0;
                nb = 0;
            end else begin
                if (x < 0) begin
                    x = -x; y = -y;
                    z = 64'd11520 * 65536;
                end
                for (int i = 0; i < STAGES; i++) begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y < 0) begin
                        x = x - ys; y = y + xs; z -= ATAN_STEP[i];
                    end else begin
                        x = x + ys; y = y - xs; z += ATAN_STEP[i];
                    end
                end
                nr = (scale_gain(x) + 128) >>> 8;
                nb = (z + 32768) >>> 16;
                nb = ((nb % 23040) + 23040) % 23040;
            end
            f.lost = 1'b0;
            if (nr > 65535) begin
                nr = 65535;
                f.lost = 1'b1;
            end
            if (nr >= longint'(radius)) f.lost = 1'b1;
            f.rng = nr[15:0];
            f.brg = nb[14:0];
            fixes.insert(fixes.size(), f);
        endfunction

        function void check_fix(logic [15:0] rng, logic [14:0] brg, logic lost);
            t_track_fix f;
            if (fixes.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            f = fixes.pop_front();
            if (rng !== f.rng) begin
                $error("new_range: expected %0d, got %0d", f.rng, rng);
                errors++;
            end
            if (brg !== f.brg) begin
                $error("new_bearing: expected %0d, got %0d", f.brg, brg);
                errors++;
            end
            if (lost !== f.lost) begin
                $error("out_of_range: expected %0d, got %0d", f.lost, lost);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_start_range = '0;
    logic [14:0] i_start_bearing = '0;
    logic [11:0] i_target_speed = '0;
    logic [14:0] i_heading = '0;
    logic        o_valid;
    logic [15:0] o_new_range;
    logic [14:0] o_new_bearing;
    logic        o_out_of_range;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    logic [13:0] interval_shadow = 14'd100;
    logic [15:0] radius_shadow = 16'd16000;
    bit          quiet = 1'b0;
    track_scoreboard sb = new();

    polar_target_position_update #(.CORDIC_STAGES(STAGES)) dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Sample all three channels mid-cycle, where nothing changes
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_INTERVAL_MS) interval_shadow = i_cfg_data[13:0];
                else if (i_cfg_index == CFG_DETECT_RADIUS) radius_shadow = i_cfg_data;
            end
            if (start && !busy)
                sb.note_target(i_start_range, i_start_bearing, i_target_speed, i_heading,
                               interval_shadow, radius_shadow);
            if (o_valid) sb.check_fix(o_new_range, o_new_bearing, o_out_of_range);
        end
    end

    // Optional idle cycles ahead of a transaction
    task automatic idle_gap();
        while (!quiet && $urandom_range(99) < 8) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_target(logic [15:0] rng, logic [14:0] brg, logic [11:0] spd,
                               logic [14:0] hdg);
        bit took;
        idle_gap();
        start <= 1'b1;
        i_start_range <= rng;
        i_start_bearing <= brg;
        i_target_speed <= spd;
        i_heading <= hdg;
        do begin
            @(negedge i_clk);
            took = !busy;
            @(posedge i_clk);
        end while (!took);
    endtask

    // Let every target drain before touching a register
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.fixes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        bit took;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do begin
            @(negedge i_clk);
            took = o_cfg_ready;
            @(posedge i_clk);
        end while (!took);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_targets(int count);
        logic [15:0] rng;
        logic [11:0] spd;
        for (int n = 0; n < count; n++) begin
            quiet = (n >= count / 3 && n < count / 2);
            case ($urandom_range(3))
                0: rng = 16'($urandom_range(255));
                1: rng = 16'(16'hFFFF - $urandom_range(511));
                default: rng = 16'($urandom);
            endcase
            spd = ($urandom_range(7) == 0) ? 12'd0 : 12'($urandom);
            send_target(rng, 15'($urandom), spd, 15'($urandom));
            if (n == count / 2) drain();
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, wrap of angles, zero motion, cancellation
        send_target(16'd0, 15'd0, 12'd0, 15'd0);
        send_target(16'hFFFF, 15'd0, 12'hFFF, 15'd0);
        send_target(16'hFFFF, 15'd23039, 12'hFFF, 15'd23039);
        send_target(16'd1000, 15'd23040, 12'd50, 15'h7FFF);
        send_target(16'd1000, 15'h7FFF, 12'd50, 15'd23040);
        send_target(16'd5000, 15'd5760, 12'd0, 15'd0);
        send_target(16'd5000, 15'd5761, 12'd100, 15'd11520);
        send_target(16'd5000, 15'd17280, 12'd100, 15'd17281);
        send_target(16'd5000, 15'd11520, 12'd100, 15'd0);
        send_target(16'd15999, 15'd0, 12'd0, 15'd0);
        send_target(16'd16000, 15'd0, 12'd0, 15'd0);
        send_target(16'd16, 15'd0, 12'd160, 15'd11520);
        send_target(16'd0, 15'd0, 12'd1, 15'd5760);
        send_target(16'hFFF0, 15'd2880, 12'hFFF, 15'd2880);
        drain();

        // Extreme register settings, including ignored indexes
        write_reg(CFG_INTERVAL_MS, 16'd0);
        write_reg(CFG_DETECT_RADIUS, 16'd0);
        write_reg(CFG_SPARE_2, 16'hFFFF);
        write_reg(CFG_SPARE_3, 16'h1234);
        send_target(16'd0, 15'd0, 12'hFFF, 15'd100);
        send_target(16'd3000, 15'd700, 12'hFFF, 15'd9000);
        random_targets(250);
        drain();

        write_reg(CFG_INTERVAL_MS, 16'h3FFF);
        write_reg(CFG_DETECT_RADIUS, 16'hFFFF);
        send_target(16'hFFFF, 15'd0, 12'hFFF, 15'd0);
        random_targets(350);
        drain();

        write_reg(CFG_INTERVAL_MS, 16'd1);
        write_reg(CFG_DETECT_RADIUS, 16'd1);
        random_targets(300);
        drain();

        write_reg(CFG_INTERVAL_MS, 16'd10000);
        write_reg(CFG_DETECT_RADIUS, 16'd30000);
        random_targets(350);
        drain();

        for (int p = 0; p < 2; p++) begin
            write_reg(CFG_INTERVAL_MS, 16'($urandom_range(16383)));
            write_reg(CFG_DETECT_RADIUS, 16'($urandom));
            random_targets(300);
            drain();
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.errors == 0 && sb.fixes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (sb.fixes.size() != 0) $error("%0d results never arrived", sb.fixes.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
